>>> rtl/fp32mac_pkg.sv
// ----------------------------------------------------------------------------
// fp32mac_pkg
// Shared types, register codes and single-precision arithmetic helpers for
// the multiply-accumulate element array.
// ----------------------------------------------------------------------------
package fp32mac_pkg;

   localparam int ROWS_DEF      = 4;
   localparam int COLS_DEF      = 4;
   localparam int MAX_DELAY_DEF = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MUL_DELAY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ADD_DELAY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACCUM_DELAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROUND_DELAY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_DELAY    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROUND_ENABLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_ENABLE   = 3'd6;

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [31:0] POS_MAX_BITS = 32'h7F7F_FFFF;
   localparam logic [31:0] NEG_MAX_BITS = 32'hFF7F_FFFF;
   localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  row;
      logic [1:0]  col;
      logic        in_valid;
      logic [31:0] mult_a;
      logic [31:0] mult_b;
      logic [31:0] add_term;
   } req_type;

   typedef struct packed {
      logic        res_valid;
      logic [31:0] res_value;
   } rsp_type;

   // Rounds p * 2^s to single precision, nearest even. p must be nonzero.
   function automatic logic [31:0] fp_round_pack(input logic sgn, input logic [50:0] p,
                                                 input int s);
      int          l;
      int          e;
      int          et;
      int          r;
      logic [50:0] m;
      logic [50:0] mask;
      logic        g;
      logic        st;
      l = 0;
      for (int i = 0; i < 51; i++) begin
         if (p[i]) l = i;
      end
      e  = l + s + 127;
      et = (e < 1) ? 1 : e;
      r  = et - 150 - s;
      g  = 1'b0;
      st = 1'b0;
      mask = '0;
      if (r <= 0) begin
         m = p << (-r);
      end else if (r > 51) begin
         m  = '0;
         st = |p;
      end else begin
         m    = p >> r;
         g    = p[r-1];
         mask = (51'd1 << (r - 1)) - 51'd1;
         st   = |(p & mask);
      end
      if (g && (st || m[0])) m = m + 51'd1;
      if (m[24]) begin
         m  = m >> 1;
         et = et + 1;
      end
      if (et >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, (m[23] ? et[7:0] : 8'd0), m[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sgn;
      logic [23:0] ma;
      logic [23:0] mb;
      logic        a_nan;
      logic        b_nan;
      logic        a_inf;
      logic        b_inf;
      int          ea;
      int          eb;
      sgn   = a[31] ^ b[31];
      ma    = {|a[30:23], a[22:0]};
      mb    = {|b[30:23], b[22:0]};
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
      ea    = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
      eb    = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
      if (a_nan) return a | QUIET_BIT;
      if (b_nan) return b | QUIET_BIT;
      if ((a_inf && mb == '0) || (b_inf && ma == '0)) return QNAN_DEFAULT;
      if (a_inf || b_inf) return {sgn, 8'hFF, 23'd0};
      if (ma == '0 || mb == '0) return {sgn, 31'd0};
      return fp_round_pack(sgn, {3'd0, 48'(ma) * 48'(mb)}, ea + eb - 300);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] big;
      logic [31:0] sml;
      logic [50:0] pl;
      logic [50:0] ps;
      logic [50:0] sum;
      logic [50:0] mask;
      int          eb;
      int          es;
      int          d;
      logic        x_nan;
      logic        y_nan;
      logic        x_inf;
      logic        y_inf;
      x_nan = (x[30:23] == 8'hFF) && (x[22:0] != '0);
      y_nan = (y[30:23] == 8'hFF) && (y[22:0] != '0);
      x_inf = (x[30:23] == 8'hFF) && (x[22:0] == '0);
      y_inf = (y[30:23] == 8'hFF) && (y[22:0] == '0);
      if (x_nan) return x | QUIET_BIT;
      if (y_nan) return y | QUIET_BIT;
      if (x_inf && y_inf && (x[31] != y[31])) return QNAN_DEFAULT;
      if (x_inf) return x;
      if (y_inf) return y;
      if (x[30:0] == '0 && y[30:0] == '0) return {x[31] & y[31], 31'd0};
      if (x[30:0] >= y[30:0]) begin
         big = x;
         sml = y;
      end else begin
         big = y;
         sml = x;
      end
      eb = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
      es = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
      d  = eb - es;
      pl = {1'b0, |big[30:23], big[22:0], 26'd0};
      ps = {1'b0, |sml[30:23], sml[22:0], 26'd0};
      mask = '0;
      if (d >= 51) begin
         ps = {50'd0, |ps};
      end else if (d > 0) begin
         mask = (51'd1 << d) - 51'd1;
         ps   = (ps >> d) | {50'd0, |(ps & mask)};
      end
      sum = (big[31] == sml[31]) ? pl + ps : pl - ps;
      if (sum == '0) return 32'd0;
      return fp_round_pack(big[31], sum, eb - 176);
   endfunction

   // Round to an integral value, ties to even. NaN and infinities pass.
   function automatic logic [31:0] fp_round_int(input logic [31:0] b);
      logic [7:0]  ex;
      logic [25:0] m;
      logic [25:0] half;
      logic [25:0] ip;
      logic [25:0] rem;
      int          sh;
      ex = b[30:23];
      if (ex >= 8'd150) return b;
      if (ex < 8'd126) return {b[31], 31'd0};
      sh   = 150 - int'(ex);
      m    = {2'b01, b[22:0]};
      half = 26'd1 << (sh - 1);
      ip   = m >> sh;
      rem  = m & ((26'd1 << sh) - 26'd1);
      if (rem > half || (rem == half && ip[0])) ip = ip + 26'd1;
      m = ip << sh;
      if (m == '0) return {b[31], 31'd0};
      if (m[24]) return {b[31], ex + 8'd1, m[23:1]};
      return {b[31], ex, m[22:0]};
   endfunction

   function automatic logic [31:0] fp_saturate(input logic [31:0] b);
      if (b[30:23] != 8'hFF) return b;
      if (b[22:0] == '0 && !b[31]) return POS_MAX_BITS;
      return NEG_MAX_BITS;
   endfunction

endpackage

>>> rtl/fp32_mac_array_element_step_top.sv
// ----------------------------------------------------------------------------
// fp32_mac_array_element_step_top
// Array of single-precision multiply-accumulate elements whose accumulators
// and delay lines live in one element memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  input beats. A step beat addresses one element (row, col); a clear
//          beat wipes every accumulator and delay line. Each beat yields
//          exactly one rsp_* beat, in order.
//   rsp_*  result beats, held in an output register until rsp_ready.
//   csr_*  register writes, always ready; write only while the block is idle.
// An accepted beat passes stages 1 to 4, then the output register. Beats to
// different elements issue one per cycle while the pipeline does not hold. A
// beat to an element still in the four-stage read-modify-write pipeline waits
// until that element is written back, so one element waits on its last beat.
// Reset and clear: a sweep writes zero to each of the ROWS*COLS memory words,
// one per cycle; req_ready stays low while the sweep runs. A clear beat
// starts the same sweep when it retires.
// With a result held and rsp_ready low, the pipeline holds and req_ready drops.
// ----------------------------------------------------------------------------
module fp32_mac_array_element_step_top
   import fp32mac_pkg::*;
#(
   parameter int ROWS      = ROWS_DEF,
   parameter int COLS      = COLS_DEF,
   parameter int MAX_DELAY = MAX_DELAY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ELEMS = ROWS * COLS;
   localparam int AW    = (ELEMS > 1) ? $clog2(ELEMS) : 1;
   localparam int CW    = $clog2(ELEMS + 1);

   typedef logic [MAX_DELAY-1:0][32:0] line_type;

   typedef struct packed {
      logic [31:0] acc;
      line_type    ml;
      line_type    al;
      line_type    sl;
      line_type    rl;
      line_type    ol;
   } word_type;

   typedef struct packed {
      logic          vld;
      logic          clr;
      logic          inr;
      logic [AW-1:0] addr;
      logic          in_valid;
      logic [31:0]   a;
      logic [31:0]   b;
      logic [31:0]   c;
      logic [31:0]   v;
      logic          v_ok;
   } stage_type;

   function automatic int span_of(input logic [2:0] len);
      return (int'(len) > MAX_DELAY) ? MAX_DELAY : int'(len);
   endfunction

   function automatic logic [32:0] line_tap(input line_type ln, input int span,
                                            input logic [32:0] din);
      if (span == 0) return din;
      return ln[span-1];
   endfunction

   function automatic line_type line_push(input line_type ln, input int span,
                                          input logic [32:0] din);
      line_type o;
      o = ln;
      if (span != 0) begin
         for (int i = MAX_DELAY - 1; i > 0; i--) begin
            if (i < span) o[i] = ln[i-1];
         end
         o[0] = din;
      end
      return o;
   endfunction

   // Configuration registers.
   logic [2:0] mul_delay_ff, add_delay_ff, accum_delay_ff, round_delay_ff, sat_delay_ff;
   logic       round_en_ff, sat_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_delay_ff   <= 3'd2;
         add_delay_ff   <= 3'd1;
         accum_delay_ff <= 3'd1;
         round_delay_ff <= 3'd1;
         sat_delay_ff   <= 3'd0;
         round_en_ff    <= 1'b1;
         sat_en_ff      <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MUL_DELAY:    mul_delay_ff   <= csr_data;
            REG_ADD_DELAY:    add_delay_ff   <= csr_data;
            REG_ACCUM_DELAY:  accum_delay_ff <= csr_data;
            REG_ROUND_DELAY:  round_delay_ff <= csr_data;
            REG_SAT_DELAY:    sat_delay_ff   <= csr_data;
            REG_ROUND_ENABLE: round_en_ff    <= csr_data[0];
            REG_SAT_ENABLE:   sat_en_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Pipeline control.
   stage_type st1_ff, st2_ff, st3_ff, st4_ff;
   stage_type st1_in, st2_in, st3_in, st4_in;
   word_type  rd_ff, wd2_ff, wd3_ff, wd4_ff;
   word_type  wd3_in, wd4_in, wb_word;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_vld_ff;
   logic      clearing_ff, clearing_in;
   logic [CW-1:0] sweep_ff, sweep_in;

   logic          advance;
   logic          hazard;
   logic          req_inr;
   logic [AW-1:0] req_addr;
   logic          accept;

   assign advance  = !rsp_vld_ff || rsp_ready;
   assign req_inr  = (int'(req_data.row) < ROWS) && (int'(req_data.col) < COLS);
   assign req_addr = AW'(int'(req_data.row) * COLS + int'(req_data.col));

   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < 4; k++) begin
         stage_type s;
         s = (k == 0) ? st1_ff : (k == 1) ? st2_ff : (k == 2) ? st3_ff : st4_ff;
         if (s.vld && (s.clr || (s.inr && req_inr && s.addr == req_addr))) hazard = 1'b1;
      end
   end

   assign req_ready = advance && !hazard && !clearing_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      st1_in          = '0;
      st1_in.vld      = accept;
      st1_in.clr      = (req_data.cmd == CMD_CLEAR);
      st1_in.inr      = req_inr;
      st1_in.addr     = req_addr;
      st1_in.in_valid = req_data.in_valid;
      st1_in.a        = req_data.mult_a;
      st1_in.b        = req_data.mult_b;
      st1_in.c        = req_data.add_term;
   end

   // Stage 1: product.
   always_comb begin
      st2_in   = st1_ff;
      st2_in.v = fp_mul(st1_ff.a, st1_ff.b);
   end

   // Stage 2: product line, then the addend sum.
   logic [32:0] mul_tap;
   always_comb begin
      int span;
      span      = span_of(mul_delay_ff);
      mul_tap   = line_tap(wd2_ff.ml, span, {st2_ff.in_valid, st2_ff.v});
      wd3_in    = wd2_ff;
      wd3_in.ml = line_push(wd2_ff.ml, span, {st2_ff.in_valid, st2_ff.v});
      st3_in      = st2_ff;
      st3_in.v    = fp_add(mul_tap[31:0], st2_ff.c);
      st3_in.v_ok = mul_tap[32];
   end

   // Stage 3: addend-sum line, then the accumulator update.
   logic [32:0] add_tap;
   always_comb begin
      int span;
      span      = span_of(add_delay_ff);
      add_tap   = line_tap(wd3_ff.al, span, {st3_ff.v_ok, st3_ff.v});
      wd4_in    = wd3_ff;
      wd4_in.al = line_push(wd3_ff.al, span, {st3_ff.v_ok, st3_ff.v});
      if (add_tap[32]) wd4_in.acc = fp_add(wd3_ff.acc, add_tap[31:0]);
      st4_in      = st3_ff;
      st4_in.v_ok = add_tap[32];
   end

   // Stage 4: sum, rounded and output lines; write-back and result.
   always_comb begin
      int          s_sum;
      int          s_rnd;
      int          s_out;
      logic [32:0] t;
      s_sum   = span_of(accum_delay_ff);
      s_rnd   = span_of(round_delay_ff);
      s_out   = span_of(sat_delay_ff);
      wb_word = wd4_ff;
      t = line_tap(wd4_ff.sl, s_sum, {st4_ff.v_ok, wd4_ff.acc});
      wb_word.sl = line_push(wd4_ff.sl, s_sum, {st4_ff.v_ok, wd4_ff.acc});
      if (t[32] && round_en_ff) t[31:0] = fp_round_int(t[31:0]);
      wb_word.rl = line_push(wd4_ff.rl, s_rnd, t);
      t = line_tap(wd4_ff.rl, s_rnd, t);
      if (t[32] && sat_en_ff) t[31:0] = fp_saturate(t[31:0]);
      wb_word.ol = line_push(wd4_ff.ol, s_out, t);
      t = line_tap(wd4_ff.ol, s_out, t);
      rsp_in = '0;
      if (!st4_ff.clr && st4_ff.inr && t[32]) begin
         rsp_in.res_valid = 1'b1;
         rsp_in.res_value = t[31:0];
      end
   end

   logic retire_clear;
   logic wb_en;
   assign retire_clear = advance && st4_ff.vld && st4_ff.clr;
   assign wb_en        = advance && st4_ff.vld && !st4_ff.clr && st4_ff.inr;

   always_comb begin
      clearing_in = clearing_ff;
      sweep_in    = sweep_ff;
      if (clearing_ff) begin
         if (sweep_ff == CW'(ELEMS - 1)) clearing_in = 1'b0;
         sweep_in = sweep_ff + CW'(1);
      end else if (retire_clear) begin
         clearing_in = 1'b1;
         sweep_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff.vld  <= 1'b0;
         st2_ff.vld  <= 1'b0;
         st3_ff.vld  <= 1'b0;
         st4_ff.vld  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         clearing_ff <= 1'b1;
         sweep_ff    <= '0;
      end else begin
         clearing_ff <= clearing_in;
         sweep_ff    <= sweep_in;
         if (advance) begin
            st1_ff     <= st1_in;
            st2_ff     <= st2_in;
            st3_ff     <= st3_in;
            st4_ff     <= st4_in;
            rsp_vld_ff <= st4_ff.vld;
            rsp_ff     <= rsp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wd2_ff <= rd_ff;
         wd3_ff <= wd3_in;
         wd4_ff <= wd4_in;
      end
   end

   // Element memory: one word per element, read at acceptance.
   word_type mem [ELEMS];

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[sweep_ff[AW-1:0]] <= '0;
      end else if (wb_en) begin
         mem[st4_ff.addr] <= wb_word;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rd_ff <= mem[req_addr];
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Checks.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_ready)
      else $error("input accepted during clearing sweep");

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.res_valid) |-> (rsp_ff.res_value == 32'd0))
      else $error("invalid result carries a nonzero value");

   a_clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      retire_clear |=> clearing_ff)
      else $error("clear retired without a sweep");

   a_no_wb_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !(st4_ff.vld && !st4_ff.clr))
      else $error("step in flight during clearing sweep");

endmodule

>>> dv/fp32_mac_array_element_step_checker.sv
// ----------------------------------------------------------------------------
// fp32_mac_array_element_step_checker
// Watches the request, result and register channels of the multiply-accumulate
// element array, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module fp32_mac_array_element_step_checker
   import fp32mac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NELEM = ROWS_DEF * COLS_DEF;
   localparam int DMAX  = MAX_DELAY_DEF;

   localparam int LN_MUL = 0;
   localparam int LN_ADD = 1;
   localparam int LN_SUM = 2;
   localparam int LN_RND = 3;
   localparam int LN_OUT = 4;

   logic [32:0] line_q [5][NELEM][DMAX];
   logic [31:0] acc_q [NELEM];
   logic [2:0]  span_reg [5];
   logic        rnd_en;
   logic        sat_en;
   rsp_type     expected_q[$];

   assign pending = expected_q.size();

   function automatic real flt_to_real(input logic [31:0] f);
      logic [23:0] sig;
      int          ex;
      sig = {|f[30:23], f[22:0]};
      ex  = (f[30:23] == 8'd0) ? 1 : int'(f[30:23]);
      return (f[31] ? -1.0 : 1.0) * real'(sig) * (2.0 ** (ex - 150));
   endfunction

   // Rounds a double to single precision, nearest even, with subnormals.
   function automatic logic [31:0] real_to_flt(input real r);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          fe;
      int          sh;
      d = $realtobits(r);
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      sig = {11'd0, 1'b1, d[51:0]};
      fe  = int'(d[62:52]) - 1023 + 127;
      sh  = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 62) return {d[63], 31'd0};
      q    = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (fe < 1) return {d[63], q[30:0]};
      if (q[24]) begin
         q  = q >> 1;
         fe = fe + 1;
      end
      if (fe >= 255) return {d[63], 8'hFF, 23'd0};
      return {d[63], fe[7:0], q[22:0]};
   endfunction

   function automatic logic is_nan(input logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] != '0;
   endfunction

   function automatic logic is_inf(input logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] == '0;
   endfunction

   function automatic logic [31:0] flt_product(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if ((is_inf(a) && b[30:0] == '0) || (is_inf(b) && a[30:0] == '0)) return QNAN_DEFAULT;
      if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'd0};
      if (a[30:0] == '0 || b[30:0] == '0) return {a[31] ^ b[31], 31'd0};
      return real_to_flt(flt_to_real(a) * flt_to_real(b));
   endfunction

   function automatic logic [31:0] flt_sum(input logic [31:0] x, input logic [31:0] y);
      if (is_nan(x)) return x | QUIET_BIT;
      if (is_nan(y)) return y | QUIET_BIT;
      if (is_inf(x) && is_inf(y) && x[31] != y[31]) return QNAN_DEFAULT;
      if (is_inf(x)) return x;
      if (is_inf(y)) return y;
      if (x[30:0] == '0 && y[30:0] == '0) return {x[31] & y[31], 31'd0};
      return real_to_flt(flt_to_real(x) + flt_to_real(y));
   endfunction

   function automatic logic [31:0] flt_to_integral(input logic [31:0] f);
      logic [31:0] m;
      logic [31:0] ip;
      logic [31:0] rem;
      logic [31:0] half;
      int          sh;
      if (f[30:23] >= 8'd150) return f;
      if (f[30:23] < 8'd126) return {f[31], 31'd0};
      sh   = 150 - int'(f[30:23]);
      m    = {8'd0, 1'b1, f[22:0]};
      ip   = m >> sh;
      rem  = m & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      if (rem > half || (rem == half && ip[0])) ip = ip + 32'd1;
      m = ip << sh;
      if (m == '0) return {f[31], 31'd0};
      if (m[24]) return {f[31], f[30:23] + 8'd1, m[23:1]};
      return {f[31], f[30:23], m[22:0]};
   endfunction

   function automatic logic [31:0] flt_clamp(input logic [31:0] f);
      if (f[30:23] != 8'hFF) return f;
      if (f[22:0] == '0 && !f[31]) return POS_MAX_BITS;
      return NEG_MAX_BITS;
   endfunction

   // Shifts one element's delay line; the beat is {valid, value}.
   function automatic logic [32:0] delay_shift(input int ln, input int e, input logic [32:0] din);
      logic [32:0] dout;
      int          span;
      span = (span_reg[ln] > DMAX) ? DMAX : int'(span_reg[ln]);
      if (span == 0) return din;
      dout = line_q[ln][e][span-1];
      for (int i = span - 1; i > 0; i--) line_q[ln][e][i] = line_q[ln][e][i-1];
      line_q[ln][e][0] = din;
      return dout;
   endfunction

   function automatic void wipe_state();
      for (int k = 0; k < 5; k++)
         for (int e = 0; e < NELEM; e++) begin
            acc_q[e] = '0;
            for (int i = 0; i < DMAX; i++) line_q[k][e][i] = '0;
         end
   endfunction

   function automatic rsp_type predict_beat(input req_type rq);
      rsp_type     rs;
      logic [32:0] v;
      int          e;
      rs = '0;
      if (rq.cmd == CMD_CLEAR) begin
         wipe_state();
         return rs;
      end
      e = int'(rq.row) * COLS_DEF + int'(rq.col);
      v = delay_shift(LN_MUL, e, {rq.in_valid, flt_product(rq.mult_a, rq.mult_b)});
      v = delay_shift(LN_ADD, e, {v[32], flt_sum(v[31:0], rq.add_term)});
      if (v[32]) acc_q[e] = flt_sum(acc_q[e], v[31:0]);
      v = delay_shift(LN_SUM, e, {v[32], acc_q[e]});
      if (v[32] && rnd_en) v[31:0] = flt_to_integral(v[31:0]);
      v = delay_shift(LN_RND, e, v);
      if (v[32] && sat_en) v[31:0] = flt_clamp(v[31:0]);
      v = delay_shift(LN_OUT, e, v);
      if (v[32]) begin
         rs.res_valid = 1'b1;
         rs.res_value = v[31:0];
      end
      return rs;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         span_reg[LN_MUL] = 3'd2;
         span_reg[LN_ADD] = 3'd1;
         span_reg[LN_SUM] = 3'd1;
         span_reg[LN_RND] = 3'd1;
         span_reg[LN_OUT] = 3'd0;
         rnd_en = 1'b1;
         sat_en = 1'b0;
         wipe_state();
         expected_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MUL_DELAY:    span_reg[LN_MUL] = csr_data;
               REG_ADD_DELAY:    span_reg[LN_ADD] = csr_data;
               REG_ACCUM_DELAY:  span_reg[LN_SUM] = csr_data;
               REG_ROUND_DELAY:  span_reg[LN_RND] = csr_data;
               REG_SAT_DELAY:    span_reg[LN_OUT] = csr_data;
               REG_ROUND_ENABLE: rnd_en = csr_data[0];
               REG_SAT_ENABLE:   sat_en = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_q.push_back(predict_beat(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result beat: %h", rsp_data);
            end else begin
               want = expected_q.pop_front();
               if (want.res_valid !== rsp_data.res_valid
                   || want.res_value !== rsp_data.res_value) begin
                  errors++;
                  if (errors <= 10)
                     $display("result mismatch: valid exp %b got %b, value exp %h got %h",
                              want.res_valid, rsp_data.res_valid,
                              want.res_value, rsp_data.res_value);
               end
            end
         end
      end
   end

endmodule

>>> dv/fp32_mac_array_element_step_top_test.sv
// ----------------------------------------------------------------------------
// fp32_mac_array_element_step_top_test
// Drives directed and random step and clear beats through the element array
// under several register settings and idle patterns; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module fp32_mac_array_element_step_top_test
   import fp32mac_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    errors;
   int                    pending;
   int                    send_idle_pct;
   int                    recv_idle_pct;

   fp32_mac_array_element_step_top DUT (.*);

   fp32_mac_array_element_step_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic issue_beat(input req_type rq);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic write_delays(input logic [2:0] m, input logic [2:0] a, input logic [2:0] s,
                               input logic [2:0] r, input logic [2:0] o,
                               input logic ren, input logic sen);
      wait_drained();
      write_reg(REG_MUL_DELAY, m);
      write_reg(REG_ADD_DELAY, a);
      write_reg(REG_ACCUM_DELAY, s);
      write_reg(REG_ROUND_DELAY, r);
      write_reg(REG_SAT_DELAY, o);
      write_reg(REG_ROUND_ENABLE, {2'd0, ren});
      write_reg(REG_SAT_ENABLE, {2'd0, sen});
   endtask

   function automatic logic [31:0] modest_float();
      // Mostly values near one so that rounding and accumulation stay interesting.
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return {1'($urandom_range(1)), 8'(120 + $urandom_range(14)),
                          23'($urandom_range(3))};
         default: return {1'($urandom_range(1)), 8'(120 + $urandom_range(14)),
                          23'($urandom)};
      endcase
   endfunction

   function automatic req_type step_beat(input logic [1:0] r, input logic [1:0] c,
                                         input logic v, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] t);
      req_type rq;
      rq.cmd = CMD_STEP;
      rq.row = r;
      rq.col = c;
      rq.in_valid = v;
      rq.mult_a = a;
      rq.mult_b = b;
      rq.add_term = t;
      return rq;
   endfunction

   task automatic random_beats(input int count);
      req_type rq;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) == 0) begin
            rq = req_type'({$urandom, $urandom, $urandom, $urandom});
            rq.cmd = CMD_CLEAR;
         end else if ($urandom_range(19) == 0) begin
            rq = req_type'({$urandom, $urandom, $urandom, $urandom});
            rq.cmd = CMD_STEP;
         end else begin
            rq = step_beat(2'($urandom_range(3)), 2'($urandom_range(3)),
                           $urandom_range(9) != 0,
                           modest_float(), modest_float(), modest_float());
         end
         issue_beat(rq);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_ready = 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 86;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed beats, several on element (0,0), with short lines so results come quickly.
      write_delays(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 1'b1, 1'b1);
      issue_beat(step_beat(2'd0, 2'd0, 1'b1, 32'h3FC0_0000, 32'h3F80_0000, 32'h0000_0000));
      issue_beat(step_beat(2'd0, 2'd0, 1'b1, 32'h3F00_0000, 32'h3F80_0000, 32'h8000_0000));
      issue_beat(step_beat(2'd0, 2'd0, 1'b1, 32'h4020_0000, 32'h3F80_0000, 32'h0000_0000));
      issue_beat(step_beat(2'd0, 2'd1, 1'b1, 32'h7F80_0000, 32'h0000_0000, 32'h0000_0000));
      issue_beat(step_beat(2'd0, 2'd2, 1'b1, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000));
      issue_beat(step_beat(2'd0, 2'd3, 1'b1, 32'hFF80_0000, 32'h3F80_0000, 32'h0000_0000));
      issue_beat(step_beat(2'd1, 2'd0, 1'b1, 32'h7FC1_2345, 32'h3F80_0000, 32'hFFFF_FFFF));
      issue_beat(step_beat(2'd1, 2'd1, 1'b1, 32'h0000_0001, 32'h3F00_0000, 32'h807F_FFFF));
      issue_beat(step_beat(2'd1, 2'd2, 1'b1, 32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000));
      issue_beat(step_beat(2'd3, 2'd3, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      issue_beat(step_beat(2'd2, 2'd2, 1'b1, 32'hBFC0_0000, 32'h3F80_0000, 32'h0000_0000));
      issue_beat(req_type'({CMD_CLEAR, 101'd0}));
      issue_beat(step_beat(2'd0, 2'd0, 1'b1, 32'h4B00_0001, 32'h3F80_0000, 32'h3F00_0000));
      write_delays(3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 1'b0, 1'b0);
      random_beats(150);

      write_delays(3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 1'b1, 1'b0);
      random_beats(250);
      write_delays(3'd4, 3'd0, 3'd3, 3'd0, 3'd4, 1'b1, 1'b1);
      send_idle_pct = 86;
      recv_idle_pct = 29;
      random_beats(300);
      // Let the array drain completely once with no register change.
      wait_drained();
      random_beats(100);
      write_delays(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b1);
      random_beats(250);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_delays(3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                   3'($urandom_range(7)), 3'($urandom_range(7)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      random_beats(250);
      write_delays(3'd1, 3'd2, 3'd0, 3'd5, 3'd1, 1'b1, 1'b1);
      random_beats(437);

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
